FILE: hdl/apfr_pkg.sv
// shared types, codes and character helpers for the plc frame receiver
// no dependencies; used by apfr_ctrl, apfr_dp and ascii_plc_frame_receiver
`default_nettype none

package apfr_pkg;

	// control characters
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;

	// event codes on the result channel
	localparam logic [2:0] EV_CONSUMED = 3'd0;
	localparam logic [2:0] EV_ACK      = 3'd1;
	localparam logic [2:0] EV_NAK      = 3'd2;
	localparam logic [2:0] EV_OK       = 3'd3;
	localparam logic [2:0] EV_CSUM_ERR = 3'd4;
	localparam logic [2:0] EV_OVERFLOW = 3'd5;
	localparam logic [2:0] EV_ENTRY    = 3'd6;

	// register_kind codes
	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_DECADE = 2'd1;
	localparam logic [1:0] KIND_OCTAL  = 2'd2;
	localparam logic [1:0] KIND_WORD   = 2'd3;

	// configuration register indexes
	localparam logic CFG_KIND  = 1'b0;
	localparam logic CFG_START = 1'b1;

	// frame phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_CHK_HI = 2'd2;
	localparam logic [1:0] PH_CHK_LO = 2'd3;

	localparam logic [5:0] MAX_ENTRIES = 6'd63;

	typedef struct packed {
		logic       load_byte;
		logic       step;
		logic       emit;
		logic [2:0] emit_kind;
		logic       emit_last;
		logic       dec_init;
		logic       rd_capture;
		logic       entry_next;
	} cmd_t;

	typedef struct packed {
		logic       is_acknak;
		logic       is_ack;
		logic       overflow;
		logic       chk_lo;
		logic       csum_ok;
		logic [5:0] entry_count;
		logic       word_mode;
		logic       slot_free;
		logic       char_last;
		logic       entry_last;
	} status_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
		return v;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) c = 8'h30 + {4'd0, nib};
		else c = 8'h37 + {4'd0, nib};
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/apfr_ctrl.sv
// controller state machine of the plc frame receiver
// depends on apfr_pkg; drives apfr_dp through cmd_t, reads status_t
`default_nettype none

module apfr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire apfr_pkg::status_t sts,
	output apfr_pkg::cmd_t        cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ACK   = 3'd1;
	localparam logic [2:0] ST_FRAME = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_CAP   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       need_emit;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		need_emit = sts.overflow || sts.chk_lo || !sts.is_acknak;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_byte = 1'b1;
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (!sts.is_acknak) begin
					state_d = ST_FRAME;
				end else if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = sts.is_ack ? apfr_pkg::EV_ACK : apfr_pkg::EV_NAK;
					cmd.emit_last = !(sts.overflow || sts.chk_lo);
					state_d = ST_FRAME;
				end
			end
			ST_FRAME: begin
				if (!need_emit || sts.slot_free) begin
					cmd.step = 1'b1;
					cmd.emit = need_emit;
					cmd.emit_last = 1'b1;
					state_d = ST_IDLE;
					if (sts.overflow) begin
						cmd.emit_kind = apfr_pkg::EV_OVERFLOW;
					end else if (sts.chk_lo && !sts.csum_ok) begin
						cmd.emit_kind = apfr_pkg::EV_CSUM_ERR;
					end else if (sts.chk_lo) begin
						cmd.emit_kind = apfr_pkg::EV_OK;
						if (sts.entry_count != 6'd0) begin
							cmd.emit_last = 1'b0;
							cmd.dec_init = 1'b1;
							state_d = ST_RD;
						end
					end else begin
						cmd.emit_kind = apfr_pkg::EV_CONSUMED;
					end
				end
			end
			ST_RD: begin
				state_d = ST_CAP;
			end
			ST_CAP: begin
				cmd.rd_capture = 1'b1;
				state_d = sts.char_last ? ST_EMIT : ST_RD;
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = apfr_pkg::EV_ENTRY;
					cmd.emit_last = sts.entry_last;
					cmd.entry_next = 1'b1;
					if (sts.entry_last) state_d = ST_IDLE;
					else if (sts.word_mode) state_d = ST_RD;
					else state_d = ST_EMIT;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/apfr_dp.sv
// datapath of the plc frame receiver: payload store, checksum, decode, result register
// depends on apfr_pkg; commanded by apfr_ctrl
`default_nettype none

module apfr_dp #(
	parameter int BUFFER_DEPTH = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire apfr_pkg::cmd_t    cmd,
	output apfr_pkg::status_t      sts,
	input  wire logic [1:0]        register_kind,
	input  wire logic [15:0]       start_address,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             event_kind,
	output logic [15:0]            data_word,
	output logic [5:0]             entry_index,
	output logic                   last
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [7:0]    mem [BUFFER_DEPTH];
	logic [7:0]    byte_q;
	logic [1:0]    phase_q;
	logic [AW-1:0] count_q;
	logic [7:0]    sum_q;
	logic [7:0]    chk_hi_q;
	logic [7:0]    rdata_q;
	logic [7:0]    sh_q [4];
	logic [5:0]    entry_q;
	logic [1:0]    k_q;
	logic [3:0]    t_q;
	logic          valid_q;
	logic [2:0]    kind_q;
	logic [15:0]   data_q;
	logic [5:0]    index_q;
	logic          last_q;

	logic [7:0]    len8;
	logic [6:0]    half;
	logic [5:0]    n_entries;
	logic          word_mode;
	logic          bit_mode;
	logic [4:0]    modulus;
	logic [5:0]    nib_sum;
	logic [4:0]    fold5;
	logic [2:0]    rem5;
	logic [3:0]    t_init;
	logic [3:0]    t_next;
	logic [7:0]    addr8;
	logic [3:0]    nib0;
	logic [3:0]    nib1;
	logic          bit_val;
	logic [15:0]   entry_data;
	logic          full;

	assign word_mode = (register_kind == apfr_pkg::KIND_WORD);
	assign bit_mode  = (register_kind == apfr_pkg::KIND_DECADE) ||
	                   (register_kind == apfr_pkg::KIND_OCTAL);
	assign modulus   = (register_kind == apfr_pkg::KIND_OCTAL) ? 5'd8 : 5'd10;
	assign len8      = 8'(count_q);
	assign half      = len8[7:1];
	assign full      = (count_q == AW'(BUFFER_DEPTH - 1));

	always_comb begin
		if (word_mode) n_entries = len8[7:2];
		else if (bit_mode) n_entries = (half > 7'(apfr_pkg::MAX_ENTRIES)) ?
			apfr_pkg::MAX_ENTRIES : half[5:0];
		else n_entries = 6'd0;
	end

	// start_address mod 10 from its residue mod 5 (16 is 1 mod 5, so nibbles add)
	// and its parity; mod 8 is the low three bits
	assign nib_sum = 6'(start_address[3:0]) + 6'(start_address[7:4]) +
	                 6'(start_address[11:8]) + 6'(start_address[15:12]);
	assign fold5   = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);

	always_comb begin
		if (fold5 >= 5'd15) rem5 = 3'(fold5 - 5'd15);
		else if (fold5 >= 5'd10) rem5 = 3'(fold5 - 5'd10);
		else if (fold5 >= 5'd5) rem5 = 3'(fold5 - 5'd5);
		else rem5 = fold5[2:0];
	end

	always_comb begin
		if (register_kind == apfr_pkg::KIND_OCTAL) t_init = {1'b0, start_address[2:0]};
		else if (rem5[0] == start_address[0]) t_init = {1'b0, rem5};
		else t_init = {1'b0, rem5} + 4'd5;
	end

	assign t_next = ({1'b0, t_q} == modulus - 5'd1) ? 4'd0 : t_q + 4'd1;

	// bit mode holds c0 in sh_q[1], c1 in sh_q[0]
	assign nib0    = apfr_pkg::hex_value(sh_q[1]);
	assign nib1    = apfr_pkg::hex_value(sh_q[0]);
	assign bit_val = (t_q > 4'd3) ? nib0[t_q[1:0]] : nib1[t_q[1:0]];

	always_comb begin
		if (word_mode) entry_data = {apfr_pkg::hex_value(sh_q[1]), apfr_pkg::hex_value(sh_q[0]),
			apfr_pkg::hex_value(sh_q[3]), apfr_pkg::hex_value(sh_q[2])};
		else entry_data = {15'd0, bit_val};
	end

	assign addr8 = {entry_q, k_q};

	always_comb begin
		sts.is_acknak   = (byte_q == apfr_pkg::CH_ACK) || (byte_q == apfr_pkg::CH_NAK);
		sts.is_ack      = (byte_q == apfr_pkg::CH_ACK);
		sts.overflow    = (phase_q == apfr_pkg::PH_DATA) && (byte_q != apfr_pkg::CH_ETX) && full;
		sts.chk_lo      = (phase_q == apfr_pkg::PH_CHK_LO);
		sts.csum_ok     = (chk_hi_q == apfr_pkg::hex_char(sum_q[7:4])) &&
		                  (byte_q == apfr_pkg::hex_char(sum_q[3:0]));
		sts.entry_count = n_entries;
		sts.word_mode   = word_mode;
		sts.slot_free   = !valid_q || out_ready;
		sts.char_last   = word_mode ? (k_q == 2'd3) : (k_q == 2'd1);
		sts.entry_last  = (entry_q == n_entries - 6'd1);
	end

	// payload store
	always_ff @(posedge clk) begin
		if (cmd.step && phase_q == apfr_pkg::PH_DATA &&
		    byte_q != apfr_pkg::CH_ETX && !full) begin
			mem[count_q] <= byte_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[AW'(addr8)];
	end

	// input byte, char shift register and result register fields
	always_ff @(posedge clk) begin
		if (cmd.load_byte) byte_q <= rx_byte;
		if (cmd.rd_capture) begin
			sh_q[3] <= sh_q[2];
			sh_q[2] <= sh_q[1];
			sh_q[1] <= sh_q[0];
			sh_q[0] <= rdata_q;
		end
		if (cmd.emit) begin
			kind_q  <= cmd.emit_kind;
			data_q  <= (cmd.emit_kind == apfr_pkg::EV_ENTRY) ? entry_data : 16'd0;
			index_q <= (cmd.emit_kind == apfr_pkg::EV_ENTRY) ? entry_q : 6'd0;
			last_q  <= cmd.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= apfr_pkg::PH_IDLE;
			count_q   <= '0;
			sum_q     <= 8'd0;
			chk_hi_q  <= 8'd0;
			entry_q   <= 6'd0;
			k_q       <= 2'd0;
			t_q       <= 4'd0;
			valid_q   <= 1'b0;
		end else begin
			if (cmd.step) begin
				case (phase_q)
					apfr_pkg::PH_IDLE: begin
						if (byte_q == apfr_pkg::CH_STX) begin
							count_q <= '0;
							sum_q   <= 8'd0;
							phase_q <= apfr_pkg::PH_DATA;
						end
					end
					apfr_pkg::PH_DATA: begin
						if (byte_q == apfr_pkg::CH_ETX) begin
							sum_q   <= sum_q + byte_q;
							phase_q <= apfr_pkg::PH_CHK_HI;
						end else if (full) begin
							count_q <= '0;
							sum_q   <= 8'd0;
							phase_q <= apfr_pkg::PH_IDLE;
						end else begin
							sum_q   <= sum_q + byte_q;
							count_q <= count_q + AW'(1);
						end
					end
					apfr_pkg::PH_CHK_HI: begin
						chk_hi_q <= byte_q;
						phase_q  <= apfr_pkg::PH_CHK_LO;
					end
					default: begin
						phase_q <= apfr_pkg::PH_IDLE;
					end
				endcase
			end
			if (cmd.dec_init) begin
				entry_q   <= 6'd0;
				k_q       <= 2'd0;
				t_q       <= t_init;
			end
			if (cmd.rd_capture) begin
				k_q <= sts.char_last ? 2'd0 : k_q + 2'd1;
			end
			if (cmd.entry_next) begin
				entry_q <= entry_q + 6'd1;
				t_q     <= t_next;
			end
			if (cmd.emit) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	assign out_valid   = valid_q;
	assign event_kind  = kind_q;
	assign data_word   = data_q;
	assign entry_index = index_q;
	assign last        = last_q;

endmodule

`default_nettype wire

FILE: hdl/ascii_plc_frame_receiver.sv
// top level of the ascii plc frame receiver: config registers, controller, datapath
// depends on apfr_pkg, apfr_ctrl and apfr_dp
//
//  channel   signals                                   direction  handshake
//  input     rx_byte                                   in         in_valid / in_ready
//  result    event_kind, data_word, entry_index, last  out        out_valid / out_ready
//  config    cfg_index, cfg_data                       in         cfg_we, no wait
//
// a byte passes accept, ack/nak report and frame step; the report and the frame step wait
// while the result register is still held by out_ready low
// a good frame in word mode then reads four store chars per entry, each through the
// registered read port in a read state and a capture state, plus one emit
// bit modes reduce start_address in the frame step, read two chars, then emit one entry
// per cycle unless out_ready stalls; reset idles the framer, the store needs no clearing
`default_nettype none

module ascii_plc_frame_receiver #(
	parameter int BUFFER_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_kind,
	output logic [15:0]      data_word,
	output logic [5:0]       entry_index,
	output logic             last,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	apfr_pkg::cmd_t    cmd;
	apfr_pkg::status_t sts;

	// configuration registers
	logic [1:0]  register_kind_q;
	logic [15:0] start_address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			register_kind_q <= apfr_pkg::KIND_NONE;
			start_address_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				apfr_pkg::CFG_KIND:  register_kind_q <= cfg_data[1:0];
				apfr_pkg::CFG_START: start_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencing: one byte per transaction, decode entries streamed after a good frame
	apfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, checksum, decode and result register
	apfr_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.register_kind (register_kind_q),
		.start_address (start_address_q),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.event_kind    (event_kind),
		.data_word     (data_word),
		.entry_index   (entry_index),
		.last          (last)
	);

endmodule

`default_nettype wire

FILE: tb/sv/ascii_plc_frame_receiver_test.sv
// self-checking testbench for ascii_plc_frame_receiver: directed and random byte streams
// depends on apfr_pkg and the ascii_plc_frame_receiver rtl; carries its own frame predictor
module ascii_plc_frame_receiver_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_DEPTH      = 256;
	localparam int DRAIN_CYCLES      = 16;
	localparam int TAIL_CYCLES       = 64;
	localparam int RESULT_WAIT_LIMIT = 20000;
	localparam int RANDOM_ITEMS      = 100;
	localparam int HOLD_CYCLES       = 400;
	localparam int PRINT_LIMIT       = 50;

	// one transaction on the result channel
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] data;
		logic [5:0]  entry;
		logic        last;
	} frame_event_t;

	typedef logic [7:0] byte_q_t[$];

	// how the checksum characters of a frame are produced
	typedef enum int {
		CSUM_GOOD,
		CSUM_BAD_HIGH,
		CSUM_BAD_LOW,
		CSUM_LOWER
	} csum_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  event_kind;
	logic [15:0] data_word;
	logic [5:0]  entry_index;
	logic        last;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// predictor state: framer and configuration as the block should hold them
	logic [1:0]  frm_phase;
	int          frm_len;
	logic [7:0]  frm_sum;
	logic [7:0]  frm_chk_high;
	logic [7:0]  frm_chars [0:BUFFER_DEPTH-1];
	logic [1:0]  frm_kind;
	logic [15:0] frm_start;

	frame_event_t pending_events[$];
	int           mismatch_count = 0;
	int           bytes_sent = 0;
	int           ready_gap = 0;
	bit           no_gaps = 1'b0;
	logic         rx_hold;

	ascii_plc_frame_receiver #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.data_word(data_word),
		.entry_index(entry_index),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one, none at all in burst stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
		if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
		return 4'd0;
	endfunction

	// uppercase ascii form of one nibble
	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
	endfunction

	function automatic frame_event_t make_event(input logic [2:0] kind, input logic [15:0] data,
			input logic [5:0] entry);
		frame_event_t e;
		e.kind = kind;
		e.data = data;
		e.entry = entry;
		e.last = 1'b0;
		return e;
	endfunction

	// expected decoded entries of a frame whose checksum matched
	function automatic void predict_entries();
		int count, modulus, t, i;
		logic [7:0] lo, hi;
		logic [3:0] nib;
		if (frm_kind == apfr_pkg::KIND_WORD) begin
			count = frm_len / 4;
			if (count > int'(apfr_pkg::MAX_ENTRIES)) count = apfr_pkg::MAX_ENTRIES;
			for (i = 0; i < count; i++) begin
				// first char pair is the low byte, second pair the high byte
				lo = {hex_nibble(frm_chars[4*i]), hex_nibble(frm_chars[4*i+1])};
				hi = {hex_nibble(frm_chars[4*i+2]), hex_nibble(frm_chars[4*i+3])};
				pending_events.push_back(make_event(apfr_pkg::EV_ENTRY, {hi, lo}, 6'(i)));
			end
		end else if (frm_kind == apfr_pkg::KIND_DECADE || frm_kind == apfr_pkg::KIND_OCTAL) begin
			modulus = (frm_kind == apfr_pkg::KIND_OCTAL) ? 8 : 10;
			count = frm_len / 2;
			if (count > int'(apfr_pkg::MAX_ENTRIES)) count = apfr_pkg::MAX_ENTRIES;
			for (i = 0; i < count; i++) begin
				// bit position from the full start address, upper positions in the first char
				t = (int'(frm_start) + i) % modulus;
				if (t > 3) nib = hex_nibble(frm_chars[0]) >> (t % 4);
				else nib = hex_nibble(frm_chars[1]) >> t;
				pending_events.push_back(make_event(apfr_pkg::EV_ENTRY, {15'd0, nib[0]}, 6'(i)));
			end
		end
	endfunction

	// works out every result one accepted byte causes and queues it
	function automatic void predict_byte(input logic [7:0] b);
		int first;
		first = pending_events.size();
		if (b == apfr_pkg::CH_ACK)
			pending_events.push_back(make_event(apfr_pkg::EV_ACK, 16'd0, 6'd0));
		else if (b == apfr_pkg::CH_NAK)
			pending_events.push_back(make_event(apfr_pkg::EV_NAK, 16'd0, 6'd0));
		case (frm_phase)
			apfr_pkg::PH_IDLE: begin
				if (b == apfr_pkg::CH_STX) begin
					frm_len = 0;
					frm_sum = 8'd0;
					frm_phase = apfr_pkg::PH_DATA;
				end
			end
			apfr_pkg::PH_DATA: begin
				if (b == apfr_pkg::CH_ETX) begin
					frm_sum += b;
					frm_phase = apfr_pkg::PH_CHK_HI;
				end else if (frm_len >= BUFFER_DEPTH - 1) begin
					pending_events.push_back(make_event(apfr_pkg::EV_OVERFLOW, 16'd0, 6'd0));
					frm_len = 0;
					frm_sum = 8'd0;
					frm_phase = apfr_pkg::PH_IDLE;
				end else begin
					frm_chars[frm_len] = b;
					frm_sum += b;
					frm_len++;
				end
			end
			apfr_pkg::PH_CHK_HI: begin
				frm_chk_high = b;
				frm_phase = apfr_pkg::PH_CHK_LO;
			end
			default: begin
				frm_phase = apfr_pkg::PH_IDLE;
				if (frm_chk_high == ascii_hex(frm_sum[7:4]) && b == ascii_hex(frm_sum[3:0])) begin
					pending_events.push_back(make_event(apfr_pkg::EV_OK, 16'd0, 6'd0));
					predict_entries();
				end else begin
					pending_events.push_back(make_event(apfr_pkg::EV_CSUM_ERR, 16'd0, 6'd0));
				end
			end
		endcase
		if (pending_events.size() == first)
			pending_events.push_back(make_event(apfr_pkg::EV_CONSUMED, 16'd0, 6'd0));
		pending_events[pending_events.size()-1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
		mismatch_count++;
	endtask

	// result side: random ready gaps, plus a long hold-off while rx_hold is set
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) ready_gap = pick_gap();
			if (rx_hold || ready_gap > 0) begin
				out_ready <= 1'b0;
				if (ready_gap > 0) ready_gap--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every accepted result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		frame_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("event_kind, nothing pending", 16'(event_kind), 16'd0);
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind) report_mismatch("event_kind", 16'(event_kind), 16'(want.kind));
				if (data_word !== want.data) report_mismatch("data_word", data_word, want.data);
				if (entry_index !== want.entry)
					report_mismatch("entry_index", 16'(entry_index), 16'(want.entry));
				if (last !== want.last) report_mismatch("last", 16'(last), 16'(want.last));
			end
		end
	end

	// one input transaction; valid stays up into the next byte when there is no gap
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_byte(b);
		bytes_sent++;
	endtask

	// waits, with a bound, until every expected result has been taken
	task automatic wait_for_results();
		int n;
		for (n = 0; n < RESULT_WAIT_LIMIT && pending_events.size() != 0; n++) @(posedge clk);
	endtask

	// both registers are written back to back, only with the block idle
	task automatic set_config(input logic [1:0] kind, input logic [15:0] start);
		in_valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= apfr_pkg::CFG_KIND;
		cfg_data <= {14'd0, kind};
		@(posedge clk);
		cfg_index <= apfr_pkg::CFG_START;
		cfg_data <= start;
		@(posedge clk);
		cfg_we <= 1'b0;
		frm_kind = kind;
		frm_start = start;
	endtask

	function automatic byte_q_t text_payload(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	// payload character: mostly hex of both cases, some junk, control chars now and then
	function automatic logic [7:0] random_payload_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 35) c = 8'h30 + 8'($urandom_range(0, 9));
		else if (r < 55) c = 8'h41 + 8'($urandom_range(0, 5));
		else if (r < 75) c = 8'h61 + 8'($urandom_range(0, 5));
		else if (r < 85) c = 8'($urandom_range(8'h20, 8'h7e));
		else if (r < 90) c = apfr_pkg::CH_ACK;
		else if (r < 94) c = apfr_pkg::CH_NAK;
		else if (r < 97) c = apfr_pkg::CH_STX;
		else c = 8'($urandom_range(0, 255));
		// an etx would close the frame early
		if (c == apfr_pkg::CH_ETX) c = 8'h30;
		return c;
	endfunction

	function automatic byte_q_t random_payload(input int len);
		byte_q_t q;
		for (int i = 0; i < len; i++) q.push_back(random_payload_char());
		return q;
	endfunction

	// stx, payload, etx and two checksum chars, optionally damaged
	task automatic send_frame(input byte_q_t chars, input csum_style_t style);
		logic [7:0] sum, hi, lo;
		sum = apfr_pkg::CH_ETX;
		foreach (chars[i]) sum += chars[i];
		hi = ascii_hex(sum[7:4]);
		lo = ascii_hex(sum[3:0]);
		case (style)
			CSUM_BAD_HIGH: hi ^= 8'h01;
			CSUM_BAD_LOW:  lo ^= 8'h10;
			CSUM_LOWER: begin
				// only uppercase is accepted
				if (hi >= 8'h41) hi |= 8'h20;
				if (lo >= 8'h41) lo |= 8'h20;
			end
			default: ;
		endcase
		send_byte(apfr_pkg::CH_STX);
		foreach (chars[i]) send_byte(chars[i]);
		send_byte(apfr_pkg::CH_ETX);
		send_byte(hi);
		send_byte(lo);
	endtask

	task automatic test_idle_bytes();
		set_config(apfr_pkg::KIND_NONE, 16'd0);
		send_byte(apfr_pkg::CH_ACK);
		send_byte(apfr_pkg::CH_NAK);
		send_byte(8'hff);
		send_byte(apfr_pkg::CH_ETX);
		send_byte(8'h00);
	endtask

	task automatic test_word_frames();
		byte_q_t ctrl;
		ctrl = {8'h30, apfr_pkg::CH_ACK, 8'h31, apfr_pkg::CH_NAK, apfr_pkg::CH_STX,
			8'h46, 8'h66, 8'h39};
		set_config(apfr_pkg::KIND_WORD, 16'hffff);
		// first frame fills the low store entries before any bit-mode decode
		send_frame(text_payload("12AB34cd"), CSUM_GOOD);
		// non-hex chars decode as zero, the odd tail is dropped
		send_frame(text_payload("G0zz7"), CSUM_GOOD);
		// ack, nak and stx inside a frame are payload
		send_frame(ctrl, CSUM_GOOD);
		send_frame(text_payload(""), CSUM_GOOD);
	endtask

	task automatic test_checksum_errors();
		send_frame(text_payload("AB"), CSUM_BAD_HIGH);
		send_frame(text_payload("CD"), CSUM_BAD_LOW);
		send_frame(text_payload("EE"), CSUM_LOWER);
		// ack and nak taken as checksum chars
		send_byte(apfr_pkg::CH_STX);
		send_byte(8'h31);
		send_byte(apfr_pkg::CH_ETX);
		send_byte(apfr_pkg::CH_ACK);
		send_byte(apfr_pkg::CH_NAK);
	endtask

	task automatic test_bit_modes();
		set_config(apfr_pkg::KIND_DECADE, 16'hffff);
		send_frame(text_payload("5A3C96E1"), CSUM_GOOD);
		set_config(apfr_pkg::KIND_OCTAL, 16'd0);
		send_frame(text_payload("A5c3F0e1B2d4"), CSUM_GOOD);
		// too short for one entry
		send_frame(text_payload("7"), CSUM_GOOD);
		set_config(apfr_pkg::KIND_NONE, 16'h1234);
		send_frame(text_payload("1234"), CSUM_GOOD);
	endtask

	task automatic test_entry_cap();
		set_config(apfr_pkg::KIND_OCTAL, 16'd3);
		send_frame(random_payload(130), CSUM_GOOD);
	endtask

	task automatic test_overflow();
		set_config(apfr_pkg::KIND_WORD, 16'd0);
		send_byte(apfr_pkg::CH_STX);
		repeat (BUFFER_DEPTH) send_byte(random_payload_char());
		// framer is idle again after the overflow
		send_frame(text_payload("0102"), CSUM_GOOD);
	endtask

	task automatic test_random_traffic();
		int first, since_cfg, r, len;
		logic [15:0] start;
		first = bytes_sent;
		since_cfg = bytes_sent;
		set_config(apfr_pkg::KIND_WORD, 16'd5);
		// long receiver hold-off while bytes keep coming, so the input backs up
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		while (bytes_sent - first < RANDOM_ITEMS) begin
			if (bytes_sent - since_cfg > 30) begin
				r = $urandom_range(0, 3);
				start = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(0, 65535));
				set_config(2'($urandom_range(0, 3)), start);
				since_cfg = bytes_sent;
			end
			if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(random_payload(len), CSUM_GOOD);
			end else if (r < 78) begin
				send_frame(random_payload(len), csum_style_t'($urandom_range(1, 3)));
			end else if (r < 84) begin
				// frame cut short, later bytes land in its payload
				send_byte(apfr_pkg::CH_STX);
				repeat ($urandom_range(0, 4)) send_byte(random_payload_char());
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= 8'd0;
		cfg_we <= 1'b0;
		cfg_index <= apfr_pkg::CFG_KIND;
		cfg_data <= 16'd0;
		rx_hold <= 1'b0;
		frm_phase = apfr_pkg::PH_IDLE;
		frm_len = 0;
		frm_sum = 8'd0;
		frm_chk_high = 8'd0;
		frm_kind = apfr_pkg::KIND_NONE;
		frm_start = 16'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_word_frames();
		test_checksum_errors();
		test_bit_modes();
		test_entry_cap();
		test_overflow();
		test_random_traffic();

		// let the last results drain, then a quiet tail
		in_valid <= 1'b0;
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_events.size() != 0)
			report_mismatch("results still pending", 16'(pending_events.size()), 16'd0);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end

endmodule
